[rtl/bf7_pkg.sv]
package bf7_pkg;

  // Window geometry.
  localparam int KSIZE     = 7;
  localparam int KHALF     = 3;
  // Line store: a ring of eight rows, each row split over four column-interleaved banks.
  localparam int RING_ROWS = 8;
  localparam int NSUB      = 4;

  // Arithmetic widths: a column sum of seven 8-bit values, a sum of seven column sums.
  localparam int COLSUM_W  = 11;
  localparam int TOTAL_W   = 14;
  localparam int RECIP_W   = 15;
  localparam int PROD_W    = 29;
  localparam int RSHIFT    = 20;
  // floor(s / 49) == (s * 21400) >> 20 for every s below 2^14.
  localparam logic [RECIP_W-1:0] RECIP49 = 15'd21400;
  localparam logic [7:0]         ALPHA   = 8'hFF;

  // Configuration port.
  localparam int CFG_W   = 12;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Output queue.
  localparam int FIFO_DEPTH = 8;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Everything the datapath needs about one emitted output pixel.
  typedef struct packed {
    logic                      emit;
    logic                      last;
    logic                      row_start;
    logic [1:0]                col_phase;
    logic [KSIZE-1:0]          row_ok;
    logic [NSUB-1:0]           col_ok;
    logic [KSIZE-1:0][2:0]     bank;
  } emit_info_t;

  typedef struct packed {
    logic valid;
    logic row_start;
  } lane_ctl_t;

  typedef struct packed {
    logic   last;
    pixel_t pix;
  } out_word_t;

endpackage

[rtl/bf7_ram.sv]
module bf7_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bf7_ctrl.sv]
module bf7_ctrl #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int CE  = CW + 1,
  localparam int RW  = $clog2(MAX_HEIGHT + 1),
  localparam int RE  = RW + 1,
  localparam int AW  = $clog2((MAX_WIDTH + 3) / 4),
  localparam int MW  = (CE > RE) ? CE : RE,
  localparam int CLW = (MW > 12) ? MW : 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [bf7_pkg::CFG_W-1:0]      cfg_wdata_i,
  output logic [bf7_pkg::PDATA_W-1:0]    cfg_rdata_o,
  // Accepted input word
  input  logic                           step_i,
  input  logic                           kind_i,
  input  bf7_pkg::pixel_t                pix_i,
  // Line store write
  output logic                           wr_en_o,
  output logic [2:0]                     wr_bank_o,
  output logic [1:0]                     wr_sub_o,
  output logic [AW-1:0]                  wr_addr_o,
  output bf7_pkg::pixel_t                wr_data_o,
  // Line store read, one address per column bank
  output logic [bf7_pkg::NSUB-1:0][AW-1:0] rd_addr_o,
  output bf7_pkg::emit_info_t            info_o
);

  logic [bf7_pkg::CFG_W-1:0] width_raw_q, height_raw_q;
  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  bf7_pkg::emit_info_t info_q, info_d;

  logic [CE-1:0]  w_c;
  logic [RW-1:0]  h_c;
  logic [CLW-1:0] w_ext, h_ext;
  logic           is_pixel, restart, ready;
  logic [CW-1:0]  ic0, oc0, ic1, oc1;
  logic [RW-1:0]  ir0, or0, ir1, or1;
  logic [CE-1:0]  ic_inc, oc_inc, nc, nc_raw, col_k;
  logic [RE-1:0]  nr, nr_raw, rp;
  logic [1:0]     k_off;

  // Effective frame size, clamped to 1..maximum.
  always_comb begin
    w_ext = CLW'(width_raw_q);
    h_ext = CLW'(height_raw_q);
    if (w_ext == '0) begin
      w_c = CE'(1);
    end else if (w_ext > CLW'(MAX_WIDTH)) begin
      w_c = CE'(MAX_WIDTH);
    end else begin
      w_c = w_ext[CE-1:0];
    end
    if (h_ext == '0) begin
      h_c = RW'(1);
    end else if (h_ext > CLW'(MAX_HEIGHT)) begin
      h_c = RW'(MAX_HEIGHT);
    end else begin
      h_c = h_ext[RW-1:0];
    end
  end

  always_comb begin
    is_pixel = (bf7_pkg::kind_e'(kind_i) == bf7_pkg::KIND_PIXEL);
    restart  = is_pixel && ((in_row_q >= h_c) || (CE'(in_col_q) >= w_c));
    ir0 = restart ? '0 : in_row_q;
    ic0 = restart ? '0 : in_col_q;
    or0 = restart ? '0 : out_row_q;
    oc0 = restart ? '0 : out_col_q;

    // Input position after this word.
    ic_inc = CE'(ic0) + CE'(1);
    ir1 = ir0;
    ic1 = ic0;
    if (is_pixel) begin
      if (ic_inc >= w_c) begin
        ic1 = '0;
        ir1 = ir0 + RW'(1);
      end else begin
        ic1 = ic_inc[CW-1:0];
      end
    end

    // An output is ready once its bottom-right neighbour (clamped to the frame) is in.
    nr_raw = RE'(or0) + RE'(bf7_pkg::KHALF);
    nr     = (nr_raw < RE'(h_c)) ? nr_raw : (RE'(h_c) - RE'(1));
    nc_raw = CE'(oc0) + CE'(bf7_pkg::KHALF);
    nc     = (nc_raw < w_c) ? nc_raw : (w_c - CE'(1));
    ready  = step_i && (or0 < h_c) &&
             ((nr < RE'(ir1)) || ((nr == RE'(ir1)) && (nc < CE'(ic1))));

    oc_inc = CE'(oc0) + CE'(1);
    or1 = or0;
    oc1 = oc0;
    if (ready) begin
      if (oc_inc >= w_c) begin
        oc1 = '0;
        or1 = or0 + RW'(1);
      end else begin
        oc1 = oc_inc[CW-1:0];
      end
    end

    // Read side: columns oc0..oc0+3, each landing in a different column bank.
    for (int j = 0; j < bf7_pkg::NSUB; j++) begin
      k_off        = 2'(j) - oc0[1:0];
      col_k        = CE'(oc0) + CE'(k_off);
      rd_addr_o[j] = AW'(col_k >> 2);
    end

    info_d           = '0;
    info_d.emit      = ready;
    info_d.last      = (or0 == (h_c - RW'(1))) && (CE'(oc0) == (w_c - CE'(1)));
    info_d.row_start = (oc0 == '0);
    info_d.col_phase = oc0[1:0];
    for (int k = 0; k < bf7_pkg::NSUB; k++) begin
      info_d.col_ok[k] = (CE'(oc0) + CE'(k)) < w_c;
    end
    for (int dy = 0; dy < bf7_pkg::KSIZE; dy++) begin
      rp                = RE'(or0) + RE'(dy);
      info_d.row_ok[dy] = (rp >= RE'(bf7_pkg::KHALF)) &&
                          (rp < (RE'(h_c) + RE'(bf7_pkg::KHALF)));
      info_d.bank[dy]   = 3'(rp + RE'(bf7_pkg::RING_ROWS - bf7_pkg::KHALF));
    end
    if (!ready) begin
      info_d.row_ok = '0;
    end

    in_row_d  = step_i ? ir1 : in_row_q;
    in_col_d  = step_i ? ic1 : in_col_q;
    out_row_d = step_i ? or1 : out_row_q;
    out_col_d = step_i ? oc1 : out_col_q;
    if (cfg_we_i) begin
      in_row_d  = '0;
      in_col_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
    end
  end

  assign wr_en_o   = step_i && is_pixel;
  assign wr_bank_o = 3'(ir0);
  assign wr_sub_o  = ic0[1:0];
  assign wr_addr_o = AW'(ic0 >> 2);
  assign wr_data_o = pix_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_raw_q  <= bf7_pkg::CFG_W'(512);
      height_raw_q <= bf7_pkg::CFG_W'(512);
      in_row_q     <= '0;
      in_col_q     <= '0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      info_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (bf7_pkg::reg_idx_e'(cfg_idx_i))
          bf7_pkg::REG_FRAME_WIDTH:  width_raw_q  <= cfg_wdata_i;
          bf7_pkg::REG_FRAME_HEIGHT: height_raw_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
      info_q    <= info_d;
    end
  end

  always_comb begin
    case (bf7_pkg::reg_idx_e'(cfg_idx_i))
      bf7_pkg::REG_FRAME_WIDTH:  cfg_rdata_o = bf7_pkg::PDATA_W'(width_raw_q);
      bf7_pkg::REG_FRAME_HEIGHT: cfg_rdata_o = bf7_pkg::PDATA_W'(height_raw_q);
      default:                   cfg_rdata_o = '0;
    endcase
  end

  assign info_o = info_q;

endmodule

[rtl/bf7_lane.sv]
module bf7_lane (
  input  logic                                         clk_i,
  input  bf7_pkg::lane_ctl_t                           ctl_i,
  input  logic [bf7_pkg::NSUB-1:0][bf7_pkg::KSIZE-1:0][7:0] col_i,
  output logic [7:0]                                   mean_o
);

  logic [bf7_pkg::NSUB-1:0][bf7_pkg::COLSUM_W-1:0]  new_sum;
  logic [bf7_pkg::KSIZE-1:0][bf7_pkg::COLSUM_W-1:0] cs_q, cs_d;
  logic [bf7_pkg::TOTAL_W-1:0] tot_q, tot_d;
  logic [bf7_pkg::PROD_W-1:0]  prod_q;

  // Column sums of the four fresh columns; the window slides one column per output.
  always_comb begin
    for (int k = 0; k < bf7_pkg::NSUB; k++) begin
      new_sum[k] = '0;
      for (int dy = 0; dy < bf7_pkg::KSIZE; dy++) begin
        new_sum[k] = new_sum[k] + bf7_pkg::COLSUM_W'(col_i[k][dy]);
      end
    end
    cs_d = cs_q;
    if (ctl_i.valid) begin
      for (int i = 0; i < bf7_pkg::KHALF; i++) begin
        cs_d[i] = ctl_i.row_start ? '0 : cs_q[i+1];
      end
      for (int k = 0; k < bf7_pkg::NSUB; k++) begin
        cs_d[bf7_pkg::KHALF+k] = new_sum[k];
      end
    end
    tot_d = '0;
    for (int i = 0; i < bf7_pkg::KSIZE; i++) begin
      tot_d = tot_d + bf7_pkg::TOTAL_W'(cs_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    cs_q   <= cs_d;
    tot_q  <= tot_d;
    prod_q <= bf7_pkg::PROD_W'(tot_q) * bf7_pkg::PROD_W'(bf7_pkg::RECIP49);
  end

  assign mean_o = prod_q[bf7_pkg::RSHIFT +: 8];

endmodule

[rtl/bf7_merge.sv]
module bf7_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic                        last_i,
  input  logic [7:0]                  red_i,
  input  logic [7:0]                  green_i,
  input  logic [7:0]                  blue_i,
  output logic [bf7_pkg::CNT_W-1:0]   count_o,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [31:0]                 m_tdata_o,
  output logic                        m_tlast_o
);

  bf7_pkg::out_word_t              mem_q [bf7_pkg::FIFO_DEPTH];
  bf7_pkg::out_word_t              word;
  logic [bf7_pkg::FPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [bf7_pkg::CNT_W-1:0]       count_q;
  logic                            pop;

  always_comb begin
    word.last      = last_i;
    word.pix.red   = red_i;
    word.pix.green = green_i;
    word.pix.blue  = blue_i;
  end

  assign pop = m_tvalid_o && m_tready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + bf7_pkg::FPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + bf7_pkg::FPTR_W'(1);
      end
      count_q <= count_q + bf7_pkg::CNT_W'(push_i) - bf7_pkg::CNT_W'(pop);
    end
  end

  assign count_o    = count_q;
  assign m_tvalid_o = (count_q != '0);
  assign m_tdata_o  = {bf7_pkg::ALPHA, mem_q[rd_ptr_q].pix};
  assign m_tlast_o  = mem_q[rd_ptr_q].last;

endmodule

[rtl/box_filter_7x7_rgb_unit.sv]
// 7x7 box filter (mean) on an RGB pixel stream.
// The slave stream carries pixels in raster order, one word per pixel; tuser
// marks a word as a pixel or as a flush tick that carries no colour and only
// lets pending outputs drain at the end of a frame. The master stream gives
// one word per output pixel: the floor of the 7x7 neighbourhood sum over 49
// per channel, with pixels outside the frame counted as zero, alpha fixed at
// 255 and tlast on the final pixel of the frame. An input word yields at most
// one output word.
// Frame width and height sit in two registers on the APB port; writing either
// one restarts the frame. Write them only while the stream is idle.
// Throughput is one word per clock while tready is high. The window is summed
// by three channel lanes in a four-stage pipeline (line-store read, column
// sums, window sum, multiply by the reciprocal of 49), and each result passes
// from the multiply stage into the output queue.
// The eight-row line store is split into 32 RAMs by row and by column modulo
// four, so the four columns an output needs are read in the same cycle.
// Reset sets both dimensions to 512 and all positions to zero; the line
// store is not cleared. When the receiver stalls, results collect in an
// eight-word output queue and tready drops only when the queue and the
// pipeline together hold eight words.
module box_filter_7x7_rgb_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [23:0]                     s_axis_tdata_i,  // red_in, green_in, blue_in
  input  logic                            s_axis_tuser_i,  // kind
  // Output stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [31:0]                     m_axis_tdata_o,  // red, green, blue, alpha
  output logic                            m_axis_tlast_o,  // last_of_frame
  // Configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bf7_pkg::PADDR_W-1:0]     paddr,
  input  logic [bf7_pkg::PDATA_W-1:0]     pwdata,
  output logic [bf7_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  localparam int AW        = $clog2((MAX_WIDTH + 3) / 4);
  localparam int RAM_DEPTH = (MAX_WIDTH + 3) / 4;

  logic                     step, cfg_we;
  bf7_pkg::pixel_t          pix_in;
  logic                     wr_en;
  logic [2:0]               wr_bank;
  logic [1:0]               wr_sub;
  logic [AW-1:0]            wr_addr;
  bf7_pkg::pixel_t          wr_data, wdata_q;
  logic [bf7_pkg::NSUB-1:0][AW-1:0] rd_addr;
  bf7_pkg::emit_info_t      info;

  logic [bf7_pkg::RING_ROWS-1:0][bf7_pkg::NSUB-1:0] ram_we, fwd_q;
  logic [23:0] ram_rd [bf7_pkg::RING_ROWS][bf7_pkg::NSUB];

  logic [2:0][bf7_pkg::NSUB-1:0][bf7_pkg::KSIZE-1:0][7:0] lane_pix;
  bf7_pkg::lane_ctl_t lane_ctl;
  logic [2:0][7:0]    lane_mean;

  // Valid and tlast travel beside the lane pipeline.
  logic [2:0] vp_q, lp_q;
  logic [2:0] inflight;
  logic [bf7_pkg::CNT_W-1:0] q_count;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign step   = s_axis_tvalid_i && s_axis_tready_o;
  assign pix_in = bf7_pkg::pixel_t'(s_axis_tdata_i);

  bf7_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (paddr[2]),
    .cfg_wdata_i (pwdata[bf7_pkg::CFG_W-1:0]),
    .cfg_rdata_o (prdata),
    .step_i      (step),
    .kind_i      (s_axis_tuser_i),
    .pix_i       (pix_in),
    .wr_en_o     (wr_en),
    .wr_bank_o   (wr_bank),
    .wr_sub_o    (wr_sub),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr),
    .info_o      (info)
  );

  // Line store: one RAM per ring row and column bank. A read that hits the
  // pixel written in the same cycle takes the new pixel from a bypass.
  for (genvar b = 0; b < bf7_pkg::RING_ROWS; b++) begin : g_row
    for (genvar j = 0; j < bf7_pkg::NSUB; j++) begin : g_sub
      assign ram_we[b][j] = wr_en && (wr_bank == 3'(b)) && (wr_sub == 2'(j));

      bf7_ram #(
        .WIDTH ($bits(bf7_pkg::pixel_t)),
        .DEPTH (RAM_DEPTH)
      ) u_ram (
        .clk_i   (clk_i),
        .we_i    (ram_we[b][j]),
        .waddr_i (wr_addr),
        .wdata_i (wr_data),
        .raddr_i (rd_addr[j]),
        .rdata_o (ram_rd[b][j])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    wdata_q <= wr_data;
    for (int b = 0; b < bf7_pkg::RING_ROWS; b++) begin
      for (int j = 0; j < bf7_pkg::NSUB; j++) begin
        fwd_q[b][j] <= ram_we[b][j] && (wr_addr == rd_addr[j]);
      end
    end
  end

  // Pick each window row from its ring bank, zero the padding, split channels.
  always_comb begin : p_gather
    logic [2:0]  bnk;
    logic [1:0]  sb;
    logic [23:0] d;
    for (int dy = 0; dy < bf7_pkg::KSIZE; dy++) begin
      for (int k = 0; k < bf7_pkg::NSUB; k++) begin
        bnk = info.bank[dy];
        sb  = info.col_phase + 2'(k);
        d   = fwd_q[bnk][sb] ? wdata_q : ram_rd[bnk][sb];
        if (!(info.row_ok[dy] && info.col_ok[k])) begin
          d = '0;
        end
        for (int ch = 0; ch < 3; ch++) begin
          lane_pix[ch][k][dy] = d[ch*8 +: 8];
        end
      end
    end
  end

  assign lane_ctl.valid     = info.emit;
  assign lane_ctl.row_start = info.row_start;

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    bf7_lane u_lane (
      .clk_i  (clk_i),
      .ctl_i  (lane_ctl),
      .col_i  (lane_pix[ch]),
      .mean_o (lane_mean[ch])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= '0;
      lp_q <= '0;
    end else begin
      vp_q <= {vp_q[1:0], info.emit};
      lp_q <= {lp_q[1:0], info.last};
    end
  end

  assign inflight = 3'(info.emit) + 3'(vp_q[0]) + 3'(vp_q[1]) + 3'(vp_q[2]);

  // Accept only while the queue has room for every result still in flight.
  assign s_axis_tready_o = ((bf7_pkg::CNT_W+1)'(q_count) + (bf7_pkg::CNT_W+1)'(inflight))
                           < (bf7_pkg::CNT_W+1)'(bf7_pkg::FIFO_DEPTH);

  bf7_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (vp_q[2]),
    .last_i     (lp_q[2]),
    .red_i      (lane_mean[0]),
    .green_i    (lane_mean[1]),
    .blue_i     (lane_mean[2]),
    .count_o    (q_count),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

[rtl/bf7_checker.sv]
module bf7_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        pready
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // Alpha is constant on every word.
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[31:24] == 8'hFF)
    else $error("alpha is not 255");

  // Input back-pressure only comes from queued words.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no output word waiting");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind box_filter_7x7_rgb_unit bf7_checker u_bf7_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .pready          (pready)
);
